@@ rtl/core/fvn_pkg.sv @@
// Shared types, constants and the smoothing-table builder for the fractal value noise block.
`default_nettype none

package fvn_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 32;
    localparam int OCT_IN_W = 3;
    localparam int NOISE_W  = 24;

    // Default configuration.
    localparam int DEF_MAX_OCTAVES       = 6;
    localparam int DEF_FRAC_BITS         = 16;
    localparam int DEF_SMOOTH_TABLE_BITS = 10;

    // Hash constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] MURMUR_M  = 32'h5bd1e995;

    // Lattice corners per octave and the depth of the hash pipeline.
    localparam int CORNERS  = 8;
    localparam int HASH_LAT = 4;

    // Smoothing weight, unsigned Q1.16 so that 1.0 is representable.
    localparam int WEIGHT_W = 17;

    // Quarter turn of the sine argument in Q1.31.
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

    // Axis codes for weight lookup.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Blend schedule: four x blends, two y blends, one z blend.
    localparam int BLEND_Y_FIRST = 4;
    localparam int BLEND_Z_STEP  = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;        // capture a new input transaction
        logic       hash_issue;  // send one lattice corner into the hash pipeline
        logic [2:0] corner;      // corner index, bit 0 = x, bit 1 = y, bit 2 = z
        logic [1:0] rom_axis;    // axis whose weight index addresses the table
        logic       w_load;      // capture table output into a weight register
        logic [1:0] w_axis;      // which weight register
        logic       blend;       // one blend step on the corner queue
        logic [2:0] blend_step;  // position in the blend schedule
        logic       accum;       // fold the finished octave into the sum
        logic       div_load;    // start the normalizing division
        logic       div_step;    // one quotient bit
        logic       out_load;    // move the quotient into the result register
    } fvn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;       // no octaves requested
        logic last_octave;  // octave in progress is the final one
        logic out_busy;     // result register holds an untaken transaction
    } fvn_status_t;

    // One entry of the smoothing table: sin^2 of the scaled index, rounded to Q1.16.
    function automatic logic [WEIGHT_W-1:0] smooth_entry(input int unsigned k,
                                                         input int unsigned bits);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] sq;
        a    = (HALF_PI_Q31 * 64'(k)) >> bits;
        term = a;
        sum  = a;
        for (int m = 1; m <= 7; m++) begin
            t = (term * a) >> 31;
            t = (t * a) >> 31;
            unique case (m)
                1: t = t / 64'd6;
                2: t = t / 64'd20;
                3: t = t / 64'd42;
                4: t = t / 64'd72;
                5: t = t / 64'd110;
                6: t = t / 64'd156;
                default: t = t / 64'd210;
            endcase
            term = t;
            if (m % 2 == 1) begin
                sum = (sum >= t) ? sum - t : 64'd0;
            end else begin
                sum = sum + t;
            end
        end
        if (sum > (64'd1 << 31)) begin
            sum = 64'd1 << 31;
        end
        sq = (sum * sum + (64'd1 << 45)) >> 46;
        return sq[WEIGHT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fvn_hash.sv @@
// Four-stage pipelined corner hash: FNV-style mixing followed by a multiply finalizer.
`default_nettype none

module fvn_hash
    import fvn_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic [31:0]        in_x,
    input  wire logic [31:0]        in_y,
    input  wire logic [31:0]        in_z,
    output logic                    out_valid,
    output logic [NOISE_W-1:0]      out_hash
);

    logic [HASH_LAT-1:0] vld_reg;
    logic [HASH_LAT-1:0] vld_next;

    logic [31:0] h1_reg, h1_next;
    logic [31:0] y1_reg;
    logic [31:0] z1_reg;
    logic [31:0] h2_reg, h2_next;
    logic [31:0] z2_reg;
    logic [31:0] h3_reg, h3_next;
    logic [31:0] h4_reg, h4_next;
    logic [31:0] g3;
    logic [31:0] fin;

    // Valid bits travel alongside the data.
    assign vld_next = {vld_reg[HASH_LAT-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // One truncating 32-bit multiply per stage.
    always_comb begin
        h1_next = (FNV_BASIS ^ in_x) * FNV_PRIME;
        h2_next = (h1_reg ^ y1_reg) * FNV_PRIME;
        h3_next = (h2_reg ^ z2_reg) * FNV_PRIME;
        g3      = h3_reg ^ (h3_reg >> 13);
        h4_next = g3 * MURMUR_M;
    end

    always_ff @(posedge aclk) begin
        h1_reg <= h1_next;
        y1_reg <= in_y;
        z1_reg <= in_z;
        h2_reg <= h2_next;
        z2_reg <= z1_reg;
        h3_reg <= h3_next;
        h4_reg <= h4_next;
    end

    // Final xor-shift and truncation to the noise width.
    assign fin       = h4_reg ^ (h4_reg >> 15);
    assign out_hash  = fin[NOISE_W-1:0];
    assign out_valid = vld_reg[HASH_LAT-1];

endmodule

`default_nettype wire

@@ rtl/core/fvn_datapath.sv @@
// Datapath: coordinates, weight table, corner queue, blend unit, octave sum and divider.
`default_nettype none

module fvn_datapath
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES       = DEF_MAX_OCTAVES,
    parameter int FRAC_BITS         = DEF_FRAC_BITS,
    parameter int SMOOTH_TABLE_BITS = DEF_SMOOTH_TABLE_BITS
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic signed [COORD_W-1:0] s_px,
    input  wire logic signed [COORD_W-1:0] s_py,
    input  wire logic signed [COORD_W-1:0] s_pz,
    input  wire logic [OCT_IN_W-1:0]    s_octave_count,
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output logic [NOISE_W-1:0]          m_noise_value,
    input  wire fvn_cmd_t               cmd,
    output fvn_status_t                 status
);

    localparam int TAB_SIZE = 1 << SMOOTH_TABLE_BITS;
    localparam int SW       = FRAC_BITS + COORD_W;
    localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);
    localparam int SUM_W    = NOISE_W + MAX_OCTAVES;
    localparam int TB       = SMOOTH_TABLE_BITS;

    typedef logic [WEIGHT_W-1:0] rom_t [TAB_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < TAB_SIZE; k++) begin
            r[k] = smooth_entry(k, SMOOTH_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SMOOTH_ROM = build_rom();

    // Scaled coordinates, octave count and octave index.
    logic [SW-1:0]    sx_reg, sx_next;
    logic [SW-1:0]    sy_reg, sy_next;
    logic [SW-1:0]    sz_reg, sz_next;
    logic [OCT_W-1:0] n_reg, n_next;
    logic [OCT_W-1:0] oct_reg, oct_next;

    always_comb begin
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sz_next  = sz_reg;
        n_next   = n_reg;
        oct_next = oct_reg;
        if (cmd.load) begin
            sx_next  = {{FRAC_BITS{s_px[COORD_W-1]}}, s_px};
            sy_next  = {{FRAC_BITS{s_py[COORD_W-1]}}, s_py};
            sz_next  = {{FRAC_BITS{s_pz[COORD_W-1]}}, s_pz};
            oct_next = '0;
            if (int'(s_octave_count) > MAX_OCTAVES) begin
                n_next = OCT_W'(MAX_OCTAVES);
            end else begin
                n_next = OCT_W'(s_octave_count);
            end
        end else if (cmd.accum) begin
            // Next octave doubles the point.
            sx_next  = sx_reg << 1;
            sy_next  = sy_reg << 1;
            sz_next  = sz_reg << 1;
            oct_next = OCT_W'(oct_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        sz_reg  <= sz_next;
        n_reg   <= n_next;
        oct_reg <= oct_next;
    end

    // Lattice cells and fractions.
    logic [31:0]          cell_x, cell_y, cell_z;
    logic [FRAC_BITS-1:0] frac_x, frac_y, frac_z;
    logic [TB-1:0]        idx_x, idx_y, idx_z;

    assign cell_x = sx_reg[FRAC_BITS +: 32];
    assign cell_y = sy_reg[FRAC_BITS +: 32];
    assign cell_z = sz_reg[FRAC_BITS +: 32];
    assign frac_x = sx_reg[FRAC_BITS-1:0];
    assign frac_y = sy_reg[FRAC_BITS-1:0];
    assign frac_z = sz_reg[FRAC_BITS-1:0];

    // Table index is the top bits of the fraction, padded when the fraction is short.
    generate
        if (FRAC_BITS >= TB) begin : g_idx_trunc
            assign idx_x = frac_x[FRAC_BITS-1 -: TB];
            assign idx_y = frac_y[FRAC_BITS-1 -: TB];
            assign idx_z = frac_z[FRAC_BITS-1 -: TB];
        end else begin : g_idx_pad
            assign idx_x = {frac_x, {(TB - FRAC_BITS){1'b0}}};
            assign idx_y = {frac_y, {(TB - FRAC_BITS){1'b0}}};
            assign idx_z = {frac_z, {(TB - FRAC_BITS){1'b0}}};
        end
    endgenerate

    // Smoothing table with registered read.
    logic [TB-1:0]       rom_addr;
    logic [WEIGHT_W-1:0] rom_q_reg;

    always_comb begin
        unique case (cmd.rom_axis)
            AXIS_X:  rom_addr = idx_x;
            AXIS_Y:  rom_addr = idx_y;
            default: rom_addr = idx_z;
        endcase
    end

    always_ff @(posedge aclk) begin
        rom_q_reg <= SMOOTH_ROM[rom_addr];
    end

    // Weight registers.
    logic [WEIGHT_W-1:0] wx_reg, wy_reg, wz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.w_load) begin
            unique case (cmd.w_axis)
                AXIS_X:  wx_reg <= rom_q_reg;
                AXIS_Y:  wy_reg <= rom_q_reg;
                default: wz_reg <= rom_q_reg;
            endcase
        end
    end

    // Corner hashing.
    logic [31:0]         hx, hy, hz;
    logic                hash_valid;
    logic [NOISE_W-1:0]  hash_value;

    assign hx = cell_x + 32'(cmd.corner[0]);
    assign hy = cell_y + 32'(cmd.corner[1]);
    assign hz = cell_z + 32'(cmd.corner[2]);

    fvn_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd.hash_issue),
        .in_x      (hx),
        .in_y      (hy),
        .in_z      (hz),
        .out_valid (hash_valid),
        .out_hash  (hash_value)
    );

    // Blend unit: a + floor((b - a) * w / 2^16) on the two head entries of the queue.
    logic [NOISE_W-1:0]        q_reg  [CORNERS];
    logic [NOISE_W-1:0]        q_next [CORNERS];
    logic [WEIGHT_W-1:0]       blend_w;
    logic signed [NOISE_W:0]   blend_diff;
    logic signed [NOISE_W+WEIGHT_W+1:0] blend_prod;
    logic [NOISE_W-1:0]        blend_res;

    always_comb begin
        priority if (int'(cmd.blend_step) < BLEND_Y_FIRST) begin
            blend_w = wx_reg;
        end else if (int'(cmd.blend_step) < BLEND_Z_STEP) begin
            blend_w = wy_reg;
        end else begin
            blend_w = wz_reg;
        end
        blend_diff = $signed({1'b0, q_reg[1]}) - $signed({1'b0, q_reg[0]});
        blend_prod = blend_diff * $signed({1'b0, blend_w});
        blend_res  = q_reg[0] + blend_prod[16 +: NOISE_W];
    end

    // Corner queue: hash results shift in at the tail; each blend pops two and
    // writes its result behind the entries that remain.
    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            q_next[i] = q_reg[i];
        end
        if (hash_valid) begin
            for (int i = 0; i < CORNERS - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            q_next[CORNERS-1] = hash_value;
        end else if (cmd.blend) begin
            for (int i = 0; i < CORNERS; i++) begin
                if (i == BLEND_Z_STEP - int'(cmd.blend_step)) begin
                    q_next[i] = blend_res;
                end else if (i < CORNERS - 2) begin
                    q_next[i] = q_reg[i+2];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CORNERS; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // Octave sum in Horner form: each octave doubles the earlier ones.
    logic [SUM_W-1:0] sum_reg, sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (cmd.load) begin
            sum_next = '0;
        end else if (cmd.accum) begin
            sum_next = (sum_reg << 1) + SUM_W'(blend_res);
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    // Restoring divider by 2^n - 1, one quotient bit per cycle.
    logic [MAX_OCTAVES-1:0] rem_reg, rem_next;
    logic [MAX_OCTAVES-1:0] dvs_reg, dvs_next;
    logic [NOISE_W-1:0]     quo_reg, quo_next;
    logic [MAX_OCTAVES:0]   trial;
    logic [MAX_OCTAVES:0]   trial_sub;
    logic                   trial_ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NOISE_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        trial_ge  = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (cmd.load) begin
            // Zero octaves leave a zero quotient.
            quo_next = '0;
        end else if (cmd.div_load) begin
            rem_next = sum_reg[SUM_W-1:NOISE_W];
            quo_next = sum_reg[NOISE_W-1:0];
            for (int b = 0; b < MAX_OCTAVES; b++) begin
                dvs_next[b] = (b < int'(n_reg));
            end
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? trial_sub[MAX_OCTAVES-1:0] : trial[MAX_OCTAVES-1:0];
            quo_next = {quo_reg[NOISE_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [NOISE_W-1:0] out_data_reg, out_data_next;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = quo_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_noise_value = out_data_reg;

    // Status back to the controller.
    assign status.n_zero      = (n_reg == '0);
    assign status.last_octave = (OCT_W'(oct_reg + 1'b1) == n_reg);
    assign status.out_busy    = out_valid_reg && !m_ready;

endmodule

`default_nettype wire

@@ rtl/core/fvn_ctrl.sv @@
// Controller state machine sequencing hashing, blending, accumulation and division.
`default_nettype none

module fvn_ctrl
    import fvn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output fvn_cmd_t         cmd,
    input  wire fvn_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int STEP_W     = $clog2(NOISE_W + 1);
    localparam int HASH_LAST  = CORNERS + HASH_LAT - 1;
    localparam int BLEND_LAST = BLEND_Z_STEP;
    localparam int DIV_LAST   = NOISE_W;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        step_next  = STEP_W'(step_reg + 1'b1);
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.corner     = step_reg[2:0];
        cmd.rom_axis   = step_reg[1:0];
        cmd.w_axis     = 2'(step_reg - 1'b1);
        cmd.blend_step = step_reg[2:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                step_next = '0;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                step_next  = '0;
                state_next = status.n_zero ? ST_DONE : ST_HASH;
            end
            ST_HASH: begin
                // Issue eight corners, fetch three weights, then let the pipeline drain.
                cmd.hash_issue = (int'(step_reg) < CORNERS);
                cmd.w_load     = (step_reg >= STEP_W'(1)) && (step_reg <= STEP_W'(3));
                if (int'(step_reg) == HASH_LAST) begin
                    step_next  = '0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                cmd.blend = 1'b1;
                if (int'(step_reg) == BLEND_LAST) begin
                    cmd.accum  = 1'b1;
                    step_next  = '0;
                    state_next = status.last_octave ? ST_DIV : ST_HASH;
                end
            end
            ST_DIV: begin
                cmd.div_load = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
                if (int'(step_reg) == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                step_next = '0;
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                step_next  = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/fractal_value_noise_3d.sv @@
// Top level of the 3D fractal value noise block: controller, datapath and checks.
// Sequence for n >= 1 octaves: a start step; per octave, corner hashing through the four-stage
// hash pipeline and the blends on the shared blend multiplier; then the bit-serial divider and
// the result load. Zero octaves go from the start step straight to the result load. One item at
// a time: a new input is taken only after the result is loaded, which waits on any output stall.
// Reset: aresetn is synchronous and active low; it idles the controller, hash pipeline and result.
`default_nettype none

module fractal_value_noise_3d
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES       = DEF_MAX_OCTAVES,
    parameter int FRAC_BITS         = DEF_FRAC_BITS,
    parameter int SMOOTH_TABLE_BITS = DEF_SMOOTH_TABLE_BITS
)
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] s_px,
    input  wire logic signed [COORD_W-1:0] s_py,
    input  wire logic signed [COORD_W-1:0] s_pz,
    input  wire logic [OCT_IN_W-1:0]       s_octave_count,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [NOISE_W-1:0]             m_noise_value
);

    fvn_cmd_t    cmd;
    fvn_status_t status;

    // Sequencer.
    fvn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Arithmetic and storage.
    fvn_datapath #(
        .MAX_OCTAVES       (MAX_OCTAVES),
        .FRAC_BITS         (FRAC_BITS),
        .SMOOTH_TABLE_BITS (SMOOTH_TABLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_px           (s_px),
        .s_py           (s_py),
        .s_pz           (s_pz),
        .s_octave_count (s_octave_count),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_noise_value  (m_noise_value),
        .cmd            (cmd),
        .status         (status)
    );

    // After reset the block is idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // A new transaction is never taken in the cycle right after one was accepted.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Zero octaves produce a zero result, through the start and done states, when the output is free.
    a_zero_octaves: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_octave_count == '0 && !m_valid
        |=> ##2 m_valid && m_noise_value == '0)
        else $error("zero octaves did not give a zero result");

    // The controller never issues a corner hash or a division step while blending.
    a_no_hash_in_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.blend |-> !cmd.hash_issue && !cmd.div_step)
        else $error("blend overlaps hashing or division");

endmodule

`default_nettype wire
